// ----- rtl/lcb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lcb_pkg;

	localparam int IN_W          = 16;
	localparam int OUT_W         = 16;
	localparam int FRAC_BITS_DEF = 14;

	localparam int VW  = IN_W + 1;
	localparam int PW  = IN_W + VW;
	localparam int SW  = PW + 1;
	localparam int AW  = 51;
	localparam int MW  = AW - 1;
	localparam int IDX_W = $clog2(MW);

	localparam int NW       = 30;
	localparam int NORM_MSB = NW - 1;
	localparam int SQW      = 2 * NW + 2;
	localparam int SQRT_STEPS = SQW / 2;
	localparam int LW       = SQRT_STEPS;
	localparam int RW       = LW + 2;
	localparam int DRW      = LW + 1;

	localparam int CROSS_LAT = 5;

	localparam logic [OUT_W-1:0] OUT_POS_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_NEG_MAX = {1'b1, {(OUT_W - 1){1'b0}}};

	typedef struct packed {
		logic vld;
		logic deg;
	} pipe_ctl_t;

	typedef struct packed {
		logic [2:0][OUT_W-1:0] side;
		logic [2:0][OUT_W-1:0] upaxis;
		logic [2:0][OUT_W-1:0] view;
		logic                  degenerate;
	} lcb_res_t;

	function automatic logic [IDX_W-1:0] msb_idx(input logic [MW-1:0] x);
		logic [IDX_W-1:0] p;
		p = '0;
		for (int i = 0; i < MW; i++) begin
			if (x[i]) begin
				p = IDX_W'(i);
			end
		end
		return p;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/lcb_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface lcb_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] eye_x;
	logic signed [15:0] eye_y;
	logic signed [15:0] eye_z;
	logic signed [15:0] target_x;
	logic signed [15:0] target_y;
	logic signed [15:0] target_z;
	logic signed [15:0] head_x;
	logic signed [15:0] head_y;
	logic signed [15:0] head_z;

	modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
		head_x, head_y, head_z, input ready);
	modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
		head_x, head_y, head_z, output ready);
endinterface

interface lcb_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] side_x;
	logic signed [15:0] side_y;
	logic signed [15:0] side_z;
	logic signed [15:0] upaxis_x;
	logic signed [15:0] upaxis_y;
	logic signed [15:0] upaxis_z;
	logic signed [15:0] view_x;
	logic signed [15:0] view_y;
	logic signed [15:0] view_z;
	logic               degenerate;

	modport source (output valid, side_x, side_y, side_z, upaxis_x, upaxis_y, upaxis_z,
		view_x, view_y, view_z, degenerate, input ready);
	modport sink (input valid, side_x, side_y, side_z, upaxis_x, upaxis_y, upaxis_z,
		view_x, view_y, view_z, degenerate, output ready);
endinterface
`default_nettype wire

// ----- rtl/lcb_cross.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lcb_cross (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_vld,
	input  logic signed [lcb_pkg::IN_W-1:0] eye [3],
	input  logic signed [lcb_pkg::IN_W-1:0] tgt [3],
	input  logic signed [lcb_pkg::IN_W-1:0] head [3],
	output lcb_pkg::pipe_ctl_t              ctl,
	output logic signed [lcb_pkg::AW-1:0]   v [3],
	output logic signed [lcb_pkg::AW-1:0]   s [3],
	output logic signed [lcb_pkg::AW-1:0]   u [3]
);
	import lcb_pkg::*;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	pipe_ctl_t            ctl_s5;
	logic signed [VW-1:0] v_s1 [3], v_s2 [3], v_s3 [3], v_s4 [3], v_s5 [3];
	logic signed [IN_W-1:0] h_s1 [3];
	logic signed [PW-1:0] p_s2 [6];
	logic signed [SW-1:0] s_s3 [3], s_s4 [3], s_s5 [3];
	logic signed [AW-1:0] q_s4 [6];
	logic signed [AW-1:0] u_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			ctl_s5 <= '0;
		end else if (en) begin
			vld_s1     <= in_vld;
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			vld_s4     <= vld_s3;
			ctl_s5.vld <= vld_s4;
			ctl_s5.deg <= (s_s4[0] == '0) && (s_s4[1] == '0) && (s_s4[2] == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				v_s1[i] <= VW'(eye[i]) - VW'(tgt[i]);
				h_s1[i] <= head[i];
			end
			p_s2[0] <= PW'(h_s1[1]) * PW'(v_s1[2]);
			p_s2[1] <= PW'(h_s1[2]) * PW'(v_s1[1]);
			p_s2[2] <= PW'(h_s1[2]) * PW'(v_s1[0]);
			p_s2[3] <= PW'(h_s1[0]) * PW'(v_s1[2]);
			p_s2[4] <= PW'(h_s1[0]) * PW'(v_s1[1]);
			p_s2[5] <= PW'(h_s1[1]) * PW'(v_s1[0]);
			v_s2 <= v_s1;
			for (int i = 0; i < 3; i++) begin
				s_s3[i] <= SW'(p_s2[2 * i]) - SW'(p_s2[2 * i + 1]);
			end
			v_s3 <= v_s2;
			q_s4[0] <= AW'(v_s3[1]) * AW'(s_s3[2]);
			q_s4[1] <= AW'(v_s3[2]) * AW'(s_s3[1]);
			q_s4[2] <= AW'(v_s3[2]) * AW'(s_s3[0]);
			q_s4[3] <= AW'(v_s3[0]) * AW'(s_s3[2]);
			q_s4[4] <= AW'(v_s3[0]) * AW'(s_s3[1]);
			q_s4[5] <= AW'(v_s3[1]) * AW'(s_s3[0]);
			v_s4 <= v_s3;
			s_s4 <= s_s3;
			for (int i = 0; i < 3; i++) begin
				u_s5[i] <= q_s4[2 * i] - q_s4[2 * i + 1];
			end
			v_s5 <= v_s4;
			s_s5 <= s_s4;
		end
	end

	assign ctl = ctl_s5;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v[i] = AW'(v_s5[i]);
			s[i] = AW'(s_s5[i]);
			u[i] = u_s5[i];
		end
	end
endmodule
`default_nettype wire

// ----- rtl/lcb_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lcb_unit #(
	parameter int FRAC_BITS = lcb_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [lcb_pkg::AW-1:0]    comp [3],
	output logic        [lcb_pkg::OUT_W-1:0] res [3]
);
	import lcb_pkg::*;

	localparam int QW   = FRAC_BITS + 1;
	localparam int NUMW = NW + FRAC_BITS + 1;

	logic [MW-1:0]    mag_s1 [3], mag_s2 [3];
	logic [2:0]       neg_s1, neg_s2, neg_s3, neg_s4, nneg_s;
	logic [IDX_W-1:0] p_s2;
	logic [NW-1:0]    n_s3 [3], n_s4 [3];
	logic [2*NW-1:0]  sq_s4 [3];

	logic [SQW-1:0] rad_st  [SQRT_STEPS+1];
	logic [RW-1:0]  rem_st  [SQRT_STEPS+1];
	logic [LW-1:0]  root_st [SQRT_STEPS+1];
	logic [NW-1:0]  n_st    [SQRT_STEPS+1][3];
	logic [2:0]     neg_st  [SQRT_STEPS+1];

	logic [DRW-1:0] drem_st [QW+1][3];
	logic [QW-1:0]  dlo_st  [QW+1][3];
	logic [QW-1:0]  dq_st   [QW+1][3];
	logic [LW-1:0]  dl_st   [QW+1];
	logic [2:0]     dneg_st [QW+1];

	logic [NUMW-1:0] num [3];
	assign nneg_s = neg_st[SQRT_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= comp[i][AW-1];
				mag_s1[i] <= comp[i][AW-1] ? MW'(-comp[i]) : MW'(comp[i]);
			end
			p_s2   <= msb_idx(mag_s1[0] | mag_s1[1] | mag_s1[2]);
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			for (int i = 0; i < 3; i++) begin
				n_s3[i] <= NW'({mag_s2[i], {NORM_MSB{1'b0}}} >> p_s2);
			end
			neg_s3 <= neg_s2;
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= {{NW{1'b0}}, n_s3[i]} * {{NW{1'b0}}, n_s3[i]};
			end
			n_s4   <= n_s3;
			neg_s4 <= neg_s3;
			rad_st[0]  <= SQW'(sq_s4[0]) + SQW'(sq_s4[1]) + SQW'(sq_s4[2]);
			rem_st[0]  <= '0;
			root_st[0] <= '0;
			n_st[0]    <= n_s4;
			neg_st[0]  <= neg_s4;
		end
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		logic [RW-1:0] cur, trial;
		assign cur   = {rem_st[k][RW-3:0], rad_st[k][SQW-1 -: 2]};
		assign trial = {root_st[k], 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				rad_st[k+1] <= rad_st[k] << 2;
				if (cur >= trial) begin
					rem_st[k+1]  <= cur - trial;
					root_st[k+1] <= {root_st[k][LW-2:0], 1'b1};
				end else begin
					rem_st[k+1]  <= cur;
					root_st[k+1] <= {root_st[k][LW-2:0], 1'b0};
				end
				n_st[k+1]   <= n_st[k];
				neg_st[k+1] <= neg_st[k];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i] = NUMW'({n_st[SQRT_STEPS][i], {FRAC_BITS{1'b0}}})
				+ NUMW'(root_st[SQRT_STEPS] >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				drem_st[0][i] <= DRW'(num[i][NUMW-1:QW]);
				dlo_st[0][i]  <= num[i][QW-1:0];
				dq_st[0][i]   <= '0;
			end
			dl_st[0]   <= root_st[SQRT_STEPS];
			dneg_st[0] <= nneg_s;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [DRW-1:0] cur [3];
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				cur[i] = {drem_st[k][i][DRW-2:0], dlo_st[k][i][QW-1]};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					dlo_st[k+1][i] <= dlo_st[k][i] << 1;
					if (cur[i] >= DRW'(dl_st[k])) begin
						drem_st[k+1][i] <= cur[i] - DRW'(dl_st[k]);
						dq_st[k+1][i]   <= {dq_st[k][i][QW-2:0], 1'b1};
					end else begin
						drem_st[k+1][i] <= cur[i];
						dq_st[k+1][i]   <= {dq_st[k][i][QW-2:0], 1'b0};
					end
				end
				dl_st[k+1]   <= dl_st[k];
				dneg_st[k+1] <= dneg_st[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dneg_st[QW][i]) begin
					if (33'(dq_st[QW][i]) > 33'(OUT_NEG_MAX)) begin
						res[i] <= OUT_NEG_MAX;
					end else begin
						res[i] <= OUT_W'(-33'(dq_st[QW][i]));
					end
				end else begin
					if (33'(dq_st[QW][i]) > 33'(OUT_POS_MAX)) begin
						res[i] <= OUT_POS_MAX;
					end else begin
						res[i] <= OUT_W'(dq_st[QW][i]);
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/lookat_camera_basis.sv -----
// channel | dir | handshake     | payload
// in_ch   | in  | valid / ready | eye_*, target_*, head_* (signed 16)
// out_ch  | out | valid / ready | side_*, upaxis_*, view_* (Q2.14), degenerate
//
// One request per cycle while in_ch.ready is high; each axis runs through the
// 31-step square root and the FRAC_BITS + 1 step divider.
// arst_n clears all valid bits; payload registers are not reset.
// A stalled result moves into a one-entry skid register; in_ch.ready drops only
// while that register is full, and the whole pipeline then holds.
`timescale 1ns / 1ps
`default_nettype none
module lookat_camera_basis #(
	parameter int FRAC_BITS = lcb_pkg::FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lcb_in_if.sink    in_ch,
	lcb_out_if.source out_ch
);
	import lcb_pkg::*;

	localparam int UNIT_LAT = 5 + SQRT_STEPS + 1 + (FRAC_BITS + 1) + 1;

	logic                   en;
	logic signed [IN_W-1:0] eye [3], tgt [3], head [3];
	pipe_ctl_t              ctl_c;
	logic signed [AW-1:0]   v [3], s [3], u [3];
	logic [OUT_W-1:0]       rv [3], rs [3], ru [3];
	pipe_ctl_t              ctl_q [UNIT_LAT];
	pipe_ctl_t              ctl_last;
	lcb_res_t               res_now, skid_q, res_out;
	logic                   skid_vld_q;

	assign en          = !skid_vld_q;
	assign in_ch.ready = en;

	assign eye  = '{in_ch.eye_x, in_ch.eye_y, in_ch.eye_z};
	assign tgt  = '{in_ch.target_x, in_ch.target_y, in_ch.target_z};
	assign head = '{in_ch.head_x, in_ch.head_y, in_ch.head_z};

	lcb_cross u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (in_ch.valid),
		.eye    (eye),
		.tgt    (tgt),
		.head   (head),
		.ctl    (ctl_c),
		.v      (v),
		.s      (s),
		.u      (u)
	);

	lcb_unit #(.FRAC_BITS(FRAC_BITS)) u_view (.clk(clk), .en(en), .comp(v), .res(rv));
	lcb_unit #(.FRAC_BITS(FRAC_BITS)) u_side (.clk(clk), .en(en), .comp(s), .res(rs));
	lcb_unit #(.FRAC_BITS(FRAC_BITS)) u_up   (.clk(clk), .en(en), .comp(u), .res(ru));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < UNIT_LAT; i++) begin
				ctl_q[i] <= '0;
			end
		end else if (en) begin
			ctl_q[0] <= ctl_c;
			for (int i = 1; i < UNIT_LAT; i++) begin
				ctl_q[i] <= ctl_q[i-1];
			end
		end
	end

	assign ctl_last = ctl_q[UNIT_LAT-1];

	always_comb begin
		res_now = '0;
		if (ctl_last.deg) begin
			res_now.degenerate = 1'b1;
		end else begin
			for (int i = 0; i < 3; i++) begin
				res_now.side[i]   = rs[i];
				res_now.upaxis[i] = ru[i];
				res_now.view[i]   = rv[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			skid_vld_q <= !out_ch.ready;
		end else begin
			skid_vld_q <= ctl_last.vld && !out_ch.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			skid_q <= res_now;
		end
	end

	assign res_out = skid_vld_q ? skid_q : res_now;

	assign out_ch.valid      = skid_vld_q || ctl_last.vld;
	assign out_ch.side_x     = res_out.side[0];
	assign out_ch.side_y     = res_out.side[1];
	assign out_ch.side_z     = res_out.side[2];
	assign out_ch.upaxis_x   = res_out.upaxis[0];
	assign out_ch.upaxis_y   = res_out.upaxis[1];
	assign out_ch.upaxis_z   = res_out.upaxis[2];
	assign out_ch.view_x     = res_out.view[0];
	assign out_ch.view_y     = res_out.view[1];
	assign out_ch.view_z     = res_out.view[2];
	assign out_ch.degenerate = res_out.degenerate;
endmodule
`default_nettype wire

// ----- rtl/lcb_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lcb_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] side_x,
	input logic [15:0] side_y,
	input logic [15:0] side_z,
	input logic [15:0] upaxis_x,
	input logic [15:0] upaxis_y,
	input logic [15:0] upaxis_z,
	input logic [15:0] view_x,
	input logic [15:0] view_y,
	input logic [15:0] view_z,
	input logic        degenerate
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(view_x) && $stable(view_y)
			&& $stable(view_z) && $stable(side_x) && $stable(upaxis_x)
			&& $stable(degenerate))
		else $error("stalled result changed");

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> side_x == 16'd0 && side_y == 16'd0 && side_z == 16'd0
			&& upaxis_x == 16'd0 && upaxis_y == 16'd0 && upaxis_z == 16'd0
			&& view_x == 16'd0 && view_y == 16'd0 && view_z == 16'd0)
		else $error("degenerate result with nonzero axis");

	a_view_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> view_x != 16'd0 || view_y != 16'd0 || view_z != 16'd0)
		else $error("zero view axis on good result");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input held off with no pending result");
endmodule

bind lookat_camera_basis lcb_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.side_x     (out_ch.side_x),
	.side_y     (out_ch.side_y),
	.side_z     (out_ch.side_z),
	.upaxis_x   (out_ch.upaxis_x),
	.upaxis_y   (out_ch.upaxis_y),
	.upaxis_z   (out_ch.upaxis_z),
	.view_x     (out_ch.view_x),
	.view_y     (out_ch.view_y),
	.view_z     (out_ch.view_z),
	.degenerate (out_ch.degenerate)
);
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import lcb_pkg::*;

	localparam int FRAC      = FRAC_BITS_DEF;
	localparam int LATENCY   = FRAC + 44;
	localparam int WDOG_MAX  = 4000;
	localparam int HOLD_LEN  = 400;

	typedef struct {
		logic signed [15:0] eye [3];
		logic signed [15:0] tgt [3];
		logic signed [15:0] head [3];
	} camera_t;

	logic clk;
	logic arst_n;

	lcb_in_if  in_ch();
	lcb_out_if out_ch();

	lookat_camera_basis #(.FRAC_BITS(FRAC)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	lcb_res_t basis_q[$];
	int       n_errors;
	int       idle_cycles;
	bit       gaps_on;
	int       burst_left;
	bit       hold_req;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// unit vector in fixed point; returns 0 for a zero vector
	function automatic bit unit_axis(input longint c [3], output logic [2:0][15:0] q);
		longint unsigned m [3];
		bit              neg [3];
		longint unsigned mx, s, len, r;
		mx = 0;
		s  = 0;
		q  = '0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = c[i] < 0;
			m[i] = neg[i] ? longint'(-c[i]) : c[i];
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) return 0;
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++) m[i] >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++) m[i] <<= 1;
		end
		for (int i = 0; i < 3; i++) s += m[i] * m[i];
		len = int_sqrt(s);
		for (int i = 0; i < 3; i++) begin
			r = ((m[i] << FRAC) + (len >> 1)) / len;
			if (neg[i]) q[i] = (r > 32768) ? OUT_NEG_MAX : 16'(-longint'(r));
			else        q[i] = (r > 32767) ? OUT_POS_MAX : 16'(r);
		end
		return 1;
	endfunction

	function automatic lcb_res_t camera_basis(input camera_t c);
		longint   v [3], h [3], sd [3], up [3];
		lcb_res_t res;
		bit       ok;
		for (int i = 0; i < 3; i++) begin
			v[i] = longint'(c.eye[i]) - longint'(c.tgt[i]);
			h[i] = longint'(c.head[i]);
		end
		sd[0] = h[1] * v[2] - h[2] * v[1];
		sd[1] = h[2] * v[0] - h[0] * v[2];
		sd[2] = h[0] * v[1] - h[1] * v[0];
		up[0] = v[1] * sd[2] - v[2] * sd[1];
		up[1] = v[2] * sd[0] - v[0] * sd[2];
		up[2] = v[0] * sd[1] - v[1] * sd[0];
		ok = unit_axis(v, res.view);
		ok = ok && unit_axis(sd, res.side);
		ok = ok && unit_axis(up, res.upaxis);
		if (!ok) begin
			res.side   = '0;
			res.upaxis = '0;
			res.view   = '0;
		end
		res.degenerate = !ok;
		return res;
	endfunction

	task automatic send_request(input camera_t c);
		in_ch.valid    <= 1'b1;
		in_ch.eye_x    <= c.eye[0];
		in_ch.eye_y    <= c.eye[1];
		in_ch.eye_z    <= c.eye[2];
		in_ch.target_x <= c.tgt[0];
		in_ch.target_y <= c.tgt[1];
		in_ch.target_z <= c.tgt[2];
		in_ch.head_x   <= c.head[0];
		in_ch.head_y   <= c.head[1];
		in_ch.head_z   <= c.head[2];
		do @(posedge clk); while (!in_ch.ready);
		basis_q.insert(basis_q.size(), camera_basis(c));
		if (gaps_on) begin
			if (burst_left == 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(0, 16);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (basis_q.size() != 0) @(posedge clk);
	endtask

	function automatic camera_t make_camera(input int e0, e1, e2, t0, t1, t2,
		input int h0, h1, h2);
		camera_t c;
		c.eye[0] = 16'(e0); c.eye[1] = 16'(e1); c.eye[2] = 16'(e2);
		c.tgt[0] = 16'(t0); c.tgt[1] = 16'(t1); c.tgt[2] = 16'(t2);
		c.head[0] = 16'(h0); c.head[1] = 16'(h1); c.head[2] = 16'(h2);
		return c;
	endfunction

	function automatic logic signed [15:0] rand_coord(input int mode);
		case (mode)
			0:       return 16'($urandom);
			1:       return 16'($urandom_range(0, 64) - 32);
			2:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return 16'($urandom_range(0, 4096) - 2048);
		endcase
	endfunction

	function automatic camera_t rand_camera();
		camera_t c;
		int      mode, k;
		mode = $urandom_range(0, 3);
		for (int i = 0; i < 3; i++) begin
			c.eye[i]  = rand_coord(mode);
			c.tgt[i]  = rand_coord($urandom_range(0, 3));
			c.head[i] = rand_coord($urandom_range(0, 3));
		end
		case ($urandom_range(0, 15))
			0: c.tgt = c.eye;
			1: for (int i = 0; i < 3; i++) c.head[i] = '0;
			2: begin
				// up hint parallel to the view axis
				k = $urandom_range(0, 6) - 3;
				for (int i = 0; i < 3; i++) begin
					c.tgt[i]  = c.eye[i] - 16'($urandom_range(0, 200) - 100);
					c.head[i] = 16'(k * (c.eye[i] - c.tgt[i]));
				end
			end
			default: ;
		endcase
		return c;
	endfunction

	task automatic test_directed();
		send_request(make_camera(0, 0, 5, 0, 0, 0, 0, 1, 0));
		send_request(make_camera(1, 2, 3, 1, 2, 3, 0, 1, 0));
		send_request(make_camera(0, 0, 5, 0, 0, 0, 0, 0, 0));
		send_request(make_camera(0, 0, 5, 0, 0, 0, 0, 0, -7));
		send_request(make_camera(3, -4, 2, 1, 0, 0, 4, -8, 4));
		send_request(make_camera(32767, 32767, 32767, -32768, -32768, -32768,
			-32768, 32767, 0));
		send_request(make_camera(-32768, -32768, -32768, 32767, 32767, 32767,
			32767, -32768, -1));
		send_request(make_camera(32767, -32768, 32767, -32768, 32767, -32768,
			-32768, -32768, 32767));
		send_request(make_camera(1, 0, 0, 0, 0, 0, 0, 0, 1));
		send_request(make_camera(0, 1, 0, 0, 0, 0, 1, 0, 0));
		send_request(make_camera(-1, -1, -1, 0, 0, 0, 32767, -32768, 1));
		send_request(make_camera(0, 0, 0, 0, 0, 1, 0, -1, 0));
		send_request(make_camera(12345, -321, 999, -5, 77, -30000, 3, 3, 3));
		send_request(make_camera(-32768, 0, 0, 32767, 0, 0, 0, 32767, 0));
		send_request(make_camera(1, 1, 0, 0, 0, 0, 1, 1, 1));
		send_request(make_camera(-1, 0, 0, 0, 0, 0, 0, 0, 0));
		drain();
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++) send_request(rand_camera());
	endtask

	task automatic test_back_to_back(input int n);
		gaps_on = 0;
		for (int i = 0; i < n; i++) send_request(rand_camera());
		gaps_on = 1;
	endtask

	task automatic test_backpressure();
		hold_req = 1;
		gaps_on  = 0;
		for (int i = 0; i < 150; i++) send_request(rand_camera());
		gaps_on  = 1;
		drain();
	endtask

	// receiver: stall pattern is drawn anew at random for each phase
	initial begin
		int phase_cnt, mode;
		out_ch.ready = 1'b0;
		phase_cnt = 0;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				hold_req = 0;
			end
			if (phase_cnt == 0) begin
				mode = $urandom_range(0, 2);
				phase_cnt = 200;
			end
			phase_cnt--;
			case (mode)
				0:       out_ch.ready <= 1'b1;
				1:       out_ch.ready <= 1'($urandom_range(0, 1));
				default: out_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	function automatic void check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] got_v);
		if (exp_v !== got_v) begin
			n_errors++;
			if (n_errors <= 10)
				$display("mismatch %s: expected %0d got %0d", name,
					$signed(exp_v), $signed(got_v));
		end
	endfunction

	always @(posedge clk) begin
		lcb_res_t exp_r;
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (out_ch.valid && out_ch.ready) begin
				if (basis_q.size() == 0) begin
					n_errors++;
					if (n_errors <= 10) $display("result with no request pending");
				end else begin
					exp_r = basis_q.pop_front();
					check_field("side_x", exp_r.side[0], out_ch.side_x);
					check_field("side_y", exp_r.side[1], out_ch.side_y);
					check_field("side_z", exp_r.side[2], out_ch.side_z);
					check_field("upaxis_x", exp_r.upaxis[0], out_ch.upaxis_x);
					check_field("upaxis_y", exp_r.upaxis[1], out_ch.upaxis_y);
					check_field("upaxis_z", exp_r.upaxis[2], out_ch.upaxis_z);
					check_field("view_x", exp_r.view[0], out_ch.view_x);
					check_field("view_y", exp_r.view[1], out_ch.view_y);
					check_field("view_z", exp_r.view[2], out_ch.view_z);
					check_field("degenerate", 16'(exp_r.degenerate), 16'(out_ch.degenerate));
				end
			end
			if (idle_cycles >= WDOG_MAX) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		n_errors    = 0;
		idle_cycles = 0;
		gaps_on     = 1;
		burst_left  = 4;
		hold_req    = 0;
		arst_n      = 1'b0;
		in_ch.valid    = 1'b0;
		in_ch.eye_x    = '0;
		in_ch.eye_y    = '0;
		in_ch.eye_z    = '0;
		in_ch.target_x = '0;
		in_ch.target_y = '0;
		in_ch.target_z = '0;
		in_ch.head_x   = '0;
		in_ch.head_y   = '0;
		in_ch.head_z   = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(400);
		test_back_to_back(200);
		test_backpressure();
		test_random(450);
		drain();
		repeat (LATENCY + 20) @(posedge clk);
		if (n_errors == 0 && basis_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/lcb_pkg.sv
rtl/lcb_if.sv
rtl/lcb_cross.sv
rtl/lcb_unit.sv
rtl/lookat_camera_basis.sv
rtl/lcb_chk.sv
bench/tb_top.sv
